// ===== rtl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared constants and types for the ring buffer FIFO.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int MAX_DEPTH  = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LOG_W      = 4;
  localparam int MAX_LOG    = ADDR_W;
  localparam int OUT_DW     = 32;
  localparam int OUT_CW     = 11;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic             ok;
    logic             rd;
    logic [CNT_W-1:0] occ;
    logic [CNT_W-1:0] free;
  } res_t;

endpackage

// ===== rtl/ring_buffer_fifo.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_fifo
// Ring buffer FIFO with push, pop, peek and query transactions.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries in_mode and in_push_data. Each
// input transaction yields one result transaction on the output channel
// (out_valid/out_ready): out_ok, out_read_data, out_occupancy, out_free_slots.
// The word store is a RAM with a registered read, and the result is
// presented from the output register the cycle after accept.
// Throughput is one transaction per cycle while out_ready stays high.
// When the receiver stalls, the result is held and in_ready drops until the
// result is taken; in_ready then rises in the same cycle out_ready does.
// cfg_valid/cfg_ready/cfg_data writes log2 of the capacity in use (values
// above 10 saturate to 10) and empties the buffer; cfg_ready is always high.
// Reset (rst_n low, synchronous) empties the buffer and sets capacity 1024.
// No clearing pass is needed: a slot is read only after it was written.
// ----------------------------------------------------------------------------
module ring_buffer_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rbf_pkg::LOG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic [31:0]                in_push_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ok,
  output logic [31:0]                out_read_data,
  output logic [rbf_pkg::OUT_CW-1:0] out_occupancy,
  output logic [rbf_pkg::OUT_CW-1:0] out_free_slots
);
  import rbf_pkg::*;

  logic                  in_fire;
  logic                  cfg_fire;
  mem_req_t              mem_req;
  res_t                  res;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  res_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;

  rbf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_fire     (cfg_fire),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_mode      (mode_t'(in_mode)),
    .in_push_data (in_push_data[DATA_WIDTH-1:0]),
    .mem_req      (mem_req),
    .res          (res)
  );

  rbf_ram #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = res_r.ok;
  assign out_read_data  = res_r.rd ? OUT_DW'(rdata) : '0;
  assign out_occupancy  = OUT_CW'(res_r.occ);
  assign out_free_slots = OUT_CW'(res_r.free);

endmodule

// ===== rtl/rbf_ram.sv =====
// ----------------------------------------------------------------------------
// rbf_ram
// Single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module rbf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbf_ctrl
// Cursor tracking, capacity register and per-transaction result decode.
// ----------------------------------------------------------------------------
module rbf_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_fire,
  input  logic [rbf_pkg::LOG_W-1:0]      cfg_data,
  input  logic                           in_fire,
  input  rbf_pkg::mode_t                 in_mode,
  input  logic [rbf_pkg::DATA_WIDTH-1:0] in_push_data,
  output rbf_pkg::mem_req_t              mem_req,
  output rbf_pkg::res_t                  res
);
  import rbf_pkg::*;

  logic [LOG_W-1:0]  cap_log_r, cap_log_nxt;
  logic [CNT_W-1:0]  wc_r, wc_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  wrap_mask;
  logic [ADDR_W-1:0] slot_mask;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  used_after;

  always_comb begin
    cap       = CNT_W'(1) << cap_log_r;
    wrap_mask = (CNT_W'(1) << (cap_log_r + LOG_W'(1))) - CNT_W'(1);
    slot_mask = ADDR_W'(cap - CNT_W'(1));
    used      = (wc_r - rc_r) & wrap_mask;
  end

  always_comb begin
    wc_nxt        = wc_r;
    rc_nxt        = rc_r;
    cap_log_nxt   = cap_log_r;
    used_after    = used;
    res.ok        = 1'b1;
    res.rd        = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.waddr = wc_r[ADDR_W-1:0] & slot_mask;
    mem_req.raddr = rc_r[ADDR_W-1:0] & slot_mask;
    mem_req.wdata = in_push_data;
    case (in_mode)
      MODE_PUSH: begin
        if (used >= cap) begin
          res.ok = 1'b0;
        end else begin
          mem_req.we = in_fire;
          wc_nxt     = (wc_r + CNT_W'(1)) & wrap_mask;
          used_after = used + CNT_W'(1);
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (used == '0) begin
          res.ok = 1'b0;
        end else begin
          res.rd     = 1'b1;
          mem_req.re = in_fire;
          if (in_mode == MODE_POP) begin
            rc_nxt     = (rc_r + CNT_W'(1)) & wrap_mask;
            used_after = used - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res.occ  = used_after;
    res.free = cap - used_after;
    if (!in_fire) begin
      wc_nxt = wc_r;
      rc_nxt = rc_r;
    end
    if (cfg_fire) begin
      cap_log_nxt = (cfg_data > LOG_W'(MAX_LOG)) ? LOG_W'(MAX_LOG) : cfg_data;
      wc_nxt      = '0;
      rc_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_log_r <= LOG_W'(MAX_LOG);
      wc_r      <= '0;
      rc_r      <= '0;
    end else begin
      cap_log_r <= cap_log_nxt;
      wc_r      <= wc_nxt;
      rc_r      <= rc_nxt;
    end
  end

endmodule
